@@ rtl/nff_pkg.sv @@
// ----------------------------------------------------------------------------
// nff_pkg
// shared types, codes and helpers of the notification fragment framer
// ----------------------------------------------------------------------------
`default_nettype none

package nff_pkg;

	// message length saturation point
	localparam int MAX_MESSAGE_BYTES = 256;

	// usable notify size limits and header margin
	localparam int SAFE_BYTES    = 20;
	localparam int CEIL_BYTES    = 220;
	localparam int HEADER_MARGIN = 12;
	localparam int MTU_SAFE_MAX  = 23;
	localparam int MTU_OVERHEAD  = 3;

	localparam int MTU_W      = 10;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_MTU       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_CONNECTED = 1'b1;

	// input opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// header characters
	localparam logic [7:0] CHAR_AT    = 8'h40;
	localparam logic [7:0] CHAR_COMMA = 8'h2c;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	typedef logic [3:0] bcd_digit_t;

	typedef struct packed {
		bcd_digit_t hund;
		bcd_digit_t tens;
		bcd_digit_t ones;
	} bcd3_t;

	typedef struct packed {
		bcd_digit_t tens;
		bcd_digit_t ones;
	} bcd2_t;

	typedef struct packed {
		logic       op;
		logic [7:0] msg_length;
		logic [7:0] payload_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       fragment_end;
		logic       packet_end;
		logic       run_last;
	} out_word_t;

	// control to the fragment count unit
	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [7:0] divisor;
	} div_ctrl_t;

	// status from the fragment count unit
	typedef struct packed {
		logic  busy;
		bcd2_t total;
	} div_stat_t;

	function automatic bcd2_t bcd2_inc(input bcd2_t v);
		bcd2_t r;
		r = v;
		if (v.ones != 4'd9) begin
			r.ones = v.ones + 4'd1;
		end else begin
			r.ones = 4'd0;
			r.tens = (v.tens == 4'd9) ? 4'd0 : v.tens + 4'd1;
		end
		return r;
	endfunction

	// wraps from 999 to 000
	function automatic bcd3_t bcd3_inc(input bcd3_t v);
		bcd3_t r;
		r = v;
		if (v.ones != 4'd9) begin
			r.ones = v.ones + 4'd1;
		end else if (v.tens != 4'd9) begin
			r.ones = 4'd0;
			r.tens = v.tens + 4'd1;
		end else begin
			r.ones = 4'd0;
			r.tens = 4'd0;
			r.hund = (v.hund == 4'd9) ? 4'd0 : v.hund + 4'd1;
		end
		return r;
	endfunction

	// data bytes carried by one fragment, 8..208
	function automatic logic [7:0] data_bytes_for_mtu(input logic [MTU_W-1:0] mtu);
		logic [MTU_W-1:0] usable;
		if (mtu <= MTU_W'(MTU_SAFE_MAX)) begin
			usable = MTU_W'(SAFE_BYTES);
		end else begin
			usable = mtu - MTU_W'(MTU_OVERHEAD);
			if (usable > MTU_W'(CEIL_BYTES)) usable = MTU_W'(CEIL_BYTES);
		end
		return 8'(usable - MTU_W'(HEADER_MARGIN));
	endfunction

	function automatic logic [7:0] digit_char(input bcd_digit_t d);
		return CHAR_ZERO | {4'd0, d};
	endfunction

endpackage

`default_nettype wire

@@ rtl/nff_ceil_div.sv @@
// ----------------------------------------------------------------------------
// nff_ceil_div
// fragment count by repeated subtraction, count kept in decimal digits
// ----------------------------------------------------------------------------
`default_nettype none

module nff_ceil_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire nff_pkg::div_ctrl_t ctrl,
	output nff_pkg::div_stat_t  stat
);
	import nff_pkg::*;

	logic        busy_q;
	logic [7:0]  rem_q;
	logic [7:0]  divisor_q;
	bcd2_t       total_q;
	logic [8:0]  diff;

	// one shared subtractor: remainder minus fragment size
	assign diff = {1'b0, rem_q} - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			total_q <= '0;
		end else if (ctrl.start) begin
			busy_q  <= 1'b1;
			total_q <= '0;
		end else if (busy_q) begin
			if (rem_q == 8'd0) begin
				busy_q <= 1'b0;
			end else begin
				total_q <= bcd2_inc(total_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q     <= ctrl.dividend;
			divisor_q <= ctrl.divisor;
		end else if (busy_q && rem_q != 8'd0) begin
			// last partial fragment drops the remainder to zero
			rem_q <= (diff[8] || diff == 9'd0) ? 8'd0 : diff[7:0];
		end
	end

	assign stat.busy  = busy_q;
	assign stat.total = total_q;

endmodule

`default_nettype wire

@@ rtl/notify_fragment_framer_top.sv @@
// ----------------------------------------------------------------------------
// notify_fragment_framer_top
// splits messages into notification fragments with an ascii header
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_word): op start carries msg_length,
//   op data carries one payload byte
//   out channel (out_valid/out_ready/out_word): one framed byte per word,
//   header "@seq,part/total:" in decimal ahead of each fragment's first byte
//   config: cfg_we with cfg_index/cfg_data, index 0 peer mtu, 1 link up;
//   write only while the block is idle
// timing
//   one item at a time; in_ready is high only while the sequencer is idle
//   start word: the sequencer waits while the subtract loop counts
//   fragments (one fragment size subtracted per cycle, up to 32 fragments)
//   data word: goes out through the data state; when it opens a fragment,
//   the header state first walks every slot, skipped zero digits included
//   results leave through a single output register; when the receiver
//   stalls, the sequencer holds its place until the register is taken
// reset
//   peer mtu 23, link down, sequence 0, no message, output empty
//   while the link is down every word is taken and dropped
// ----------------------------------------------------------------------------
`default_nettype none

module notify_fragment_framer_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire nff_pkg::in_word_t                 in_word,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output nff_pkg::out_word_t                     out_word,
	input  wire                                    cfg_we,
	input  wire  [nff_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [nff_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import nff_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_HDR  = 4'b0100,
		S_DATA = 4'b1000
	} state_t;

	// header slots in emission order
	localparam logic [3:0] SLOT_AT    = 4'd0;
	localparam logic [3:0] SLOT_SEQ_H = 4'd1;
	localparam logic [3:0] SLOT_SEQ_T = 4'd2;
	localparam logic [3:0] SLOT_SEQ_O = 4'd3;
	localparam logic [3:0] SLOT_COMMA = 4'd4;
	localparam logic [3:0] SLOT_IDX_T = 4'd5;
	localparam logic [3:0] SLOT_IDX_O = 4'd6;
	localparam logic [3:0] SLOT_SLASH = 4'd7;
	localparam logic [3:0] SLOT_TOT_T = 4'd8;
	localparam logic [3:0] SLOT_TOT_O = 4'd9;
	localparam logic [3:0] SLOT_COLON = 4'd10;

	state_t            state_q;

	// configuration registers
	logic [MTU_W-1:0]  mtu_q;
	logic              link_q;

	// message state
	bcd3_t             seq_next_q;   // next sequence number to hand out
	bcd3_t             seq_cur_q;    // sequence of the running message
	bcd2_t             idx_q;        // fragment index, 1-based once started
	logic [7:0]        fdb_q;        // data bytes per fragment
	logic [7:0]        blf_q;        // bytes left in fragment
	logic [7:0]        blm_q;        // bytes left in message
	logic              active_q;
	logic [3:0]        slot_q;

	logic [7:0]        byte_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              in_fire;
	logic              out_free;
	logic              out_load;
	logic              hdr_emit;
	logic [7:0]        hdr_char;
	logic [7:0]        len_clamped;
	logic [7:0]        fdb_new;
	div_ctrl_t         div_ctrl;
	div_stat_t         div_stat;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// saturate length at the message limit
	assign len_clamped = ({2'b00, in_word.msg_length} > 10'(MAX_MESSAGE_BYTES)) ?
		8'(MAX_MESSAGE_BYTES) : in_word.msg_length;
	assign fdb_new = data_bytes_for_mtu(mtu_q);

	// fragment count runs in its own unit while the sequencer waits
	assign div_ctrl.start    = in_fire && link_q && (in_word.op == OP_START);
	assign div_ctrl.dividend = len_clamped;
	assign div_ctrl.divisor  = fdb_new;

	nff_ceil_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.stat   (div_stat)
	);

	// header slot decode, leading zeros are skipped
	always_comb begin
		hdr_emit = 1'b0;
		hdr_char = 8'h00;
		unique case (slot_q)
			SLOT_AT: begin
				hdr_emit = 1'b1;
				hdr_char = CHAR_AT;
			end
			SLOT_SEQ_H: begin
				hdr_emit = (seq_cur_q.hund != 4'd0);
				hdr_char = digit_char(seq_cur_q.hund);
			end
			SLOT_SEQ_T: begin
				hdr_emit = (seq_cur_q.hund != 4'd0) || (seq_cur_q.tens != 4'd0);
				hdr_char = digit_char(seq_cur_q.tens);
			end
			SLOT_SEQ_O: begin
				hdr_emit = 1'b1;
				hdr_char = digit_char(seq_cur_q.ones);
			end
			SLOT_COMMA: begin
				hdr_emit = 1'b1;
				hdr_char = CHAR_COMMA;
			end
			SLOT_IDX_T: begin
				hdr_emit = (idx_q.tens != 4'd0);
				hdr_char = digit_char(idx_q.tens);
			end
			SLOT_IDX_O: begin
				hdr_emit = 1'b1;
				hdr_char = digit_char(idx_q.ones);
			end
			SLOT_SLASH: begin
				hdr_emit = 1'b1;
				hdr_char = CHAR_SLASH;
			end
			SLOT_TOT_T: begin
				hdr_emit = (div_stat.total.tens != 4'd0);
				hdr_char = digit_char(div_stat.total.tens);
			end
			SLOT_TOT_O: begin
				hdr_emit = 1'b1;
				hdr_char = digit_char(div_stat.total.ones);
			end
			SLOT_COLON: begin
				hdr_emit = 1'b1;
				hdr_char = CHAR_COLON;
			end
			default: begin
				hdr_emit = 1'b0;
				hdr_char = 8'h00;
			end
		endcase
	end

	assign out_load = ((state_q == S_HDR) && hdr_emit && out_free) ||
		((state_q == S_DATA) && out_free);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q  <= MTU_W'(MTU_SAFE_MAX);
			link_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PEER_MTU:       mtu_q  <= cfg_data;
				CFG_LINK_CONNECTED: link_q <= cfg_data[0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			seq_next_q <= '0;
			seq_cur_q  <= '0;
			idx_q      <= '0;
			fdb_q      <= '0;
			blf_q      <= '0;
			blm_q      <= '0;
			active_q   <= 1'b0;
			slot_q     <= SLOT_AT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// link down: word is taken and dropped
					if (in_fire && link_q) begin
						if (in_word.op == OP_START) begin
							seq_cur_q  <= seq_next_q;
							seq_next_q <= bcd3_inc(seq_next_q);
							fdb_q      <= fdb_new;
							idx_q      <= '0;
							blf_q      <= 8'd0;
							blm_q      <= len_clamped;
							active_q   <= (len_clamped != 8'd0);
							state_q    <= S_DIV;
						end else if (active_q) begin
							if (blf_q == 8'd0) begin
								// fragment opens with a header
								idx_q   <= bcd2_inc(idx_q);
								blf_q   <= (fdb_q < blm_q) ? fdb_q : blm_q;
								slot_q  <= SLOT_AT;
								state_q <= S_HDR;
							end else begin
								state_q <= S_DATA;
							end
						end
					end
				end
				S_DIV: begin
					if (!div_stat.busy) state_q <= S_IDLE;
				end
				S_HDR: begin
					// skipped digits advance without a word
					if (!hdr_emit || out_free) begin
						slot_q <= slot_q + 4'd1;
						if (slot_q == SLOT_COLON) state_q <= S_DATA;
					end
				end
				S_DATA: begin
					if (out_free) begin
						blf_q <= blf_q - 8'd1;
						blm_q <= blm_q - 8'd1;
						if (blm_q == 8'd1) active_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) byte_q <= in_word.payload_byte;
		if (out_load) begin
			if (state_q == S_HDR) begin
				out_word_q.out_byte     <= hdr_char;
				out_word_q.is_header    <= 1'b1;
				out_word_q.fragment_end <= 1'b0;
				out_word_q.packet_end   <= 1'b0;
				out_word_q.run_last     <= 1'b0;
			end else begin
				out_word_q.out_byte     <= byte_q;
				out_word_q.is_header    <= 1'b0;
				out_word_q.fragment_end <= (blf_q == 8'd1);
				out_word_q.packet_end   <= (blm_q == 8'd1);
				out_word_q.run_last     <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire
